FILE: rtl/keyframe_track_sampler_macros.svh
// Assertion macros for the keyframe track sampler.
// Used by the top level only; no other dependencies.
`ifndef KEYFRAME_TRACK_SAMPLER_MACROS_SVH
`define KEYFRAME_TRACK_SAMPLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KTS_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KTS_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/kts_pkg.sv
// Shared types, constants and helpers for the keyframe track sampler.
// No dependencies; imported by every module of the block.
package kts_pkg;

    localparam int DEF_MAX_KEYS = 16;
    localparam int DATA_W       = 32;
    localparam int KEY_IDX_W    = 4;
    localparam int KEY_COUNT_W  = 5;
    localparam int ENTRY_W      = 4 * DATA_W;
    localparam int FRAC_BITS    = 16;
    localparam int DIV_STEPS    = FRAC_BITS + 1;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [1:0] {
        ADDR_FIRST,
        ADDR_LAST,
        ADDR_IDX
    } addr_sel_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_RD,
        RES_LO
    } res_sel_t;

    typedef struct packed {
        logic      write;
        logic      start;
        logic      rd_en;
        addr_sel_t rd_sel;
        logic      lo_load;
        logic      hi_load;
        logic      idx_inc;
        logic      res_set;
        res_sel_t  res_sel;
        logic      div_init;
        logic      div_step;
        logic      sub;
        logic      mul;
        logic      acc;
        logic      out_load;
    } kts_cmd_t;

    typedef struct packed {
        logic n_zero;
        logic q_le_rd;
        logic q_ge_rd;
        logic scan_end;
        logic div_last;
        logic comp_last;
        logic out_free;
    } kts_status_t;

    // Entry layout: {time, x, y, z}
    function automatic logic signed [DATA_W-1:0] entry_time(input logic [ENTRY_W-1:0] e);
        return e[4*DATA_W-1:3*DATA_W];
    endfunction

    function automatic logic signed [DATA_W-1:0] entry_comp(input logic [ENTRY_W-1:0] e,
                                                            input logic [1:0] c);
        logic signed [DATA_W-1:0] r;
        case (c)
            COMP_X:  r = e[3*DATA_W-1:2*DATA_W];
            COMP_Y:  r = e[2*DATA_W-1:DATA_W];
            default: r = e[DATA_W-1:0];
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/kts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on kts_pkg for default sizes.
module kts_ram import kts_pkg::*; #(
    parameter int WIDTH = ENTRY_W,
    parameter int DEPTH = DEF_MAX_KEYS
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/kts_ctrl.sv
// Sequencing state machine for the keyframe track sampler.
// Depends on kts_pkg; drives kts_dp through command and status structs.
module kts_ctrl import kts_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_action,
    output logic        s_ready,
    input  kts_status_t status,
    output kts_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FIRST,
        ST_CHK_FIRST,
        ST_RD_LAST,
        ST_CHK_LAST,
        ST_RD_SCAN,
        ST_CHK_SCAN,
        ST_DIV_INIT,
        ST_DIV_STEP,
        ST_SUB,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd        = '0;
        cmd.rd_sel = ADDR_FIRST;
        cmd.res_sel = RES_ZERO;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_SAMPLE) begin
                        cmd.start  = 1'b1;
                        state_next = ST_RD_FIRST;
                    end else begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_RD_FIRST: begin
                if (status.n_zero) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_ZERO;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ADDR_FIRST;
                    state_next = ST_CHK_FIRST;
                end
            end
            ST_CHK_FIRST: begin
                cmd.lo_load = 1'b1;
                if (status.q_le_rd) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_RD;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_RD_LAST;
                end
            end
            ST_RD_LAST: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = ADDR_LAST;
                state_next = ST_CHK_LAST;
            end
            ST_CHK_LAST: begin
                if (status.q_ge_rd) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_RD;
                    state_next  = ST_EMIT;
                end else begin
                    state_next = ST_RD_SCAN;
                end
            end
            ST_RD_SCAN: begin
                if (status.scan_end) begin
                    cmd.res_set = 1'b1;
                    cmd.res_sel = RES_LO;
                    state_next  = ST_EMIT;
                end else begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = ADDR_IDX;
                    state_next = ST_CHK_SCAN;
                end
            end
            ST_CHK_SCAN: begin
                cmd.hi_load = 1'b1;
                if (status.q_le_rd) begin
                    state_next = ST_DIV_INIT;
                end else begin
                    cmd.lo_load = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_RD_SCAN;
                end
            end
            ST_DIV_INIT: begin
                cmd.div_init = 1'b1;
                state_next   = ST_DIV_STEP;
            end
            ST_DIV_STEP: begin
                cmd.div_step = 1'b1;
                if (status.div_last) begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                cmd.sub    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.acc    = 1'b1;
                state_next = status.comp_last ? ST_EMIT : ST_SUB;
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/kts_dp.sv
// Datapath: key table, search registers, shift-subtract divider, shared
// multiplier and output register. Depends on kts_pkg and kts_ram.
module kts_dp import kts_pkg::*; #(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  kts_cmd_t                      cmd,
    output kts_status_t                   status,
    input  logic                          cfg_valid,
    input  logic [KEY_COUNT_W-1:0]        cfg_key_count,
    input  logic [KEY_IDX_W-1:0]          s_key_index,
    input  logic signed [DATA_W-1:0]      s_key_time,
    input  logic signed [DATA_W-1:0]      s_value_x,
    input  logic signed [DATA_W-1:0]      s_value_y,
    input  logic signed [DATA_W-1:0]      s_value_z,
    input  logic signed [DATA_W-1:0]      s_sample_time,
    input  logic                          m_ready,
    output logic                          m_valid,
    output logic signed [DATA_W-1:0]      m_out_x,
    output logic signed [DATA_W-1:0]      m_out_y,
    output logic signed [DATA_W-1:0]      m_out_z,
    output logic                          m_held_at_end
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int PW = 2 * DATA_W + DIV_STEPS + 2;

    logic [KEY_COUNT_W-1:0]     key_count_reg;
    logic [CW-1:0]              n_reg;
    logic [CW-1:0]              idx_reg;
    logic [CW-1:0]              n_minus1;
    logic signed [DATA_W-1:0]   q_reg;
    logic [ENTRY_W-1:0]         lo_reg;
    logic [ENTRY_W-1:0]         hi_reg;
    logic [ENTRY_W-1:0]         rd_data;
    logic signed [DATA_W-1:0]   rd_time;
    logic [AW-1:0]              rd_addr;
    logic                       key_in_range;

    logic signed [DATA_W:0]     num_c;
    logic signed [DATA_W:0]     num_reg;
    logic signed [DATA_W:0]     span_reg;
    logic [DATA_W+1:0]          rem_reg;
    logic [DATA_W+1:0]          span_ext;
    logic [DATA_W+1:0]          rem_sel;
    logic                       div_bit;
    logic                       div_bad;
    logic [DIV_STEPS-1:0]       quot_reg;
    logic [DIV_CNT_W-1:0]       div_cnt_reg;

    logic [1:0]                 comp_reg;
    logic signed [DATA_W-1:0]   a_sel;
    logic signed [DATA_W-1:0]   b_sel;
    logic signed [DATA_W:0]     diff_reg;
    logic signed [PW-1:0]       prod_reg;
    logic signed [PW-1:0]       acc_sum;

    logic signed [DATA_W-1:0]   res_x_reg;
    logic signed [DATA_W-1:0]   res_y_reg;
    logic signed [DATA_W-1:0]   res_z_reg;
    logic                       res_held_reg;

    logic                       m_valid_reg;
    logic signed [DATA_W-1:0]   out_x_reg;
    logic signed [DATA_W-1:0]   out_y_reg;
    logic signed [DATA_W-1:0]   out_z_reg;
    logic                       out_held_reg;

    assign key_in_range = (32'(s_key_index) < MAX_KEYS);
    assign n_minus1     = n_reg - CW'(1);

    always_comb begin
        case (cmd.rd_sel)
            ADDR_FIRST: rd_addr = '0;
            ADDR_LAST:  rd_addr = n_minus1[AW-1:0];
            default:    rd_addr = idx_reg[AW-1:0];
        endcase
    end

    kts_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_KEYS)
    ) u_ram (
        .aclk  (aclk),
        .we    (cmd.write && key_in_range),
        .waddr (AW'(s_key_index)),
        .wdata ({s_key_time, s_value_x, s_value_y, s_value_z}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign rd_time = entry_time(rd_data);

    // Divider: one quotient bit per step, numerator never exceeds span
    assign num_c    = {q_reg[DATA_W-1], q_reg} - {lo_reg[ENTRY_W-1], entry_time(lo_reg)};
    assign span_ext = {1'b0, span_reg};
    assign div_bit  = (rem_reg >= span_ext);
    assign div_bad  = (span_reg <= 0) || (num_reg <= 0);
    assign rem_sel  = div_bit ? (rem_reg - span_ext) : rem_reg;

    assign a_sel   = entry_comp(lo_reg, comp_reg);
    assign b_sel   = entry_comp(hi_reg, comp_reg);
    assign acc_sum = PW'(a_sel) + (prod_reg >>> FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_count_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                key_count_reg <= cfg_key_count;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            q_reg   <= s_sample_time;
            idx_reg <= CW'(1);
            if (32'(key_count_reg) > MAX_KEYS) begin
                n_reg <= CW'(MAX_KEYS);
            end else begin
                n_reg <= CW'(key_count_reg);
            end
        end
        if (cmd.idx_inc) begin
            idx_reg <= idx_reg + CW'(1);
        end
        if (cmd.lo_load) begin
            lo_reg <= rd_data;
        end
        if (cmd.hi_load) begin
            hi_reg <= rd_data;
        end

        if (cmd.div_init) begin
            num_reg      <= num_c;
            span_reg     <= {hi_reg[ENTRY_W-1], entry_time(hi_reg)} -
                            {lo_reg[ENTRY_W-1], entry_time(lo_reg)};
            rem_reg      <= {1'b0, num_c};
            quot_reg     <= '0;
            div_cnt_reg  <= '0;
            comp_reg     <= COMP_X;
            res_held_reg <= 1'b0;
        end
        if (cmd.div_step) begin
            rem_reg     <= {rem_sel[DATA_W:0], 1'b0};
            quot_reg    <= {quot_reg[DIV_STEPS-2:0], div_bit & ~div_bad};
            div_cnt_reg <= div_cnt_reg + DIV_CNT_W'(1);
        end

        if (cmd.sub) begin
            diff_reg <= (DATA_W+1)'(b_sel) - (DATA_W+1)'(a_sel);
        end
        if (cmd.mul) begin
            prod_reg <= diff_reg * $signed({1'b0, quot_reg});
        end
        if (cmd.acc) begin
            case (comp_reg)
                COMP_X:  res_x_reg <= acc_sum[DATA_W-1:0];
                COMP_Y:  res_y_reg <= acc_sum[DATA_W-1:0];
                default: res_z_reg <= acc_sum[DATA_W-1:0];
            endcase
            comp_reg <= comp_reg + 2'd1;
        end

        if (cmd.res_set) begin
            res_held_reg <= 1'b1;
            case (cmd.res_sel)
                RES_RD: begin
                    res_x_reg <= entry_comp(rd_data, COMP_X);
                    res_y_reg <= entry_comp(rd_data, COMP_Y);
                    res_z_reg <= entry_comp(rd_data, COMP_Z);
                end
                RES_LO: begin
                    res_x_reg <= entry_comp(lo_reg, COMP_X);
                    res_y_reg <= entry_comp(lo_reg, COMP_Y);
                    res_z_reg <= entry_comp(lo_reg, COMP_Z);
                end
                default: begin
                    res_x_reg <= '0;
                    res_y_reg <= '0;
                    res_z_reg <= '0;
                end
            endcase
        end

        if (cmd.out_load) begin
            out_x_reg    <= res_x_reg;
            out_y_reg    <= res_y_reg;
            out_z_reg    <= res_z_reg;
            out_held_reg <= res_held_reg;
        end
    end

    assign status.n_zero    = (n_reg == '0);
    assign status.q_le_rd   = (q_reg <= rd_time);
    assign status.q_ge_rd   = (q_reg >= rd_time);
    assign status.scan_end  = (idx_reg == n_reg);
    assign status.div_last  = (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign status.comp_last = (comp_reg == COMP_Z);
    assign status.out_free  = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_out_x       = out_x_reg;
    assign m_out_y       = out_y_reg;
    assign m_out_z       = out_z_reg;
    assign m_held_at_end = out_held_reg;

endmodule

FILE: rtl/keyframe_track_sampler.sv
// Keyframe track sampler: keyframe table with linear interpolation.
// Top level; depends on kts_pkg, kts_ctrl, kts_dp (and kts_ram below it).
//
// Usage:
//   s_* channel carries items. action = write stores key_time and the value
//   vector in slot key_index (slots at or above MAX_KEYS are dropped) and
//   gives no result. action = sample returns one beat on
//   the m_* channel with the vector at sample_time.
//   cfg_* channel writes key_count (keys in use); always ready, write it
//   only while the block is idle.
// Sample paths, shortest first: empty table, query at or before the first
//   key, at or after the last key, interpolated between keys i-1 and i
//   (longer for larger i). The table scan reads one entry at a time from the
//   single-read key memory, then a 17-step shift-subtract divider and one
//   shared multiplier used three times.
// One sample is in flight at a time; s_ready is high only between samples.
// The result sits in an output register, so a new item is taken while the
//   receiver stalls; a later result waits until that beat is taken.
// Reset clears key_count and the output valid; table contents stay undefined
//   until written.
module keyframe_track_sampler import kts_pkg::*; #(
    parameter int MAX_KEYS = DEF_MAX_KEYS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [KEY_COUNT_W-1:0]   cfg_key_count,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_action,
    input  logic [KEY_IDX_W-1:0]     s_key_index,
    input  logic signed [DATA_W-1:0] s_key_time,
    input  logic signed [DATA_W-1:0] s_value_x,
    input  logic signed [DATA_W-1:0] s_value_y,
    input  logic signed [DATA_W-1:0] s_value_z,
    input  logic signed [DATA_W-1:0] s_sample_time,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic signed [DATA_W-1:0] m_out_x,
    output logic signed [DATA_W-1:0] m_out_y,
    output logic signed [DATA_W-1:0] m_out_z,
    output logic                     m_held_at_end
);

    `include "keyframe_track_sampler_macros.svh"

    kts_cmd_t    cmd;
    kts_status_t status;

    assign cfg_ready = 1'b1;

    kts_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    kts_dp #(
        .MAX_KEYS (MAX_KEYS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .cfg_valid     (cfg_valid),
        .cfg_key_count (cfg_key_count),
        .s_key_index   (s_key_index),
        .s_key_time    (s_key_time),
        .s_value_x     (s_value_x),
        .s_value_y     (s_value_y),
        .s_value_z     (s_value_z),
        .s_sample_time (s_sample_time),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_out_x       (m_out_x),
        .m_out_y       (m_out_y),
        .m_out_z       (m_out_z),
        .m_held_at_end (m_held_at_end)
    );

    `KTS_ASSERT_NXT(a_sample_busy, aclk, aresetn, s_valid && s_ready && (s_action == ACT_SAMPLE), !s_ready, "sample accepted but block still ready")
    `KTS_ASSERT_IMP(a_no_overwrite, aclk, aresetn, cmd.out_load, status.out_free, "pending result overwritten")
    `KTS_ASSERT_IMP(a_div_busy, aclk, aresetn, cmd.div_step || cmd.mul, !s_ready && !cmd.write, "arithmetic step while idle")

endmodule
